>>> design/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg
// shared types and constants of the box affine transform unit
// ----------------------------------------------------------------------------
package aat_pkg;

    localparam int AXES        = 3;
    localparam int WEIGHT_W    = 16;
    localparam int WEIGHT_FRAC = 12;
    localparam int ROW_W       = AXES * WEIGHT_W;
    localparam int OFFSET_W    = 32;
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 6;
    localparam int REG_IDX_W   = 3;

    localparam logic [REG_IDX_W-1:0] REG_X_ROW    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_Y_ROW    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_Z_ROW    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Z = 3'd5;

    localparam logic [ROW_W-1:0] X_ROW_RESET = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] Y_ROW_RESET = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] Z_ROW_RESET = 48'h1000_0000_0000;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

>>> design/aabb_affine_transform_unit.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform_unit
// world-space bounding box of a local box under a configured affine map
// ----------------------------------------------------------------------------
// One box enters per cycle while the output is not stalled and passes through
// multiply, per-weight min/max select, exact three-term sum, and floor with
// offset add and saturation, so sustained throughput is one box per clock
// through the four-stage pipeline of 18 parallel weight multipliers. A stall
// on the output holds the pipeline in place; empty stages still fill. The
// matrix and offsets are written through the APB port at byte address 8*i
// and must only change while no box is in flight.
module aabb_affine_transform_unit
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [APB_ADDR_W-1:0]         paddr,
    input  logic [APB_DATA_W-1:0]         pwdata,
    output logic [APB_DATA_W-1:0]         prdata,
    output logic                          pready,

    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_local_min_x,
    input  logic signed [COORD_WIDTH-1:0] i_local_min_y,
    input  logic signed [COORD_WIDTH-1:0] i_local_min_z,
    input  logic signed [COORD_WIDTH-1:0] i_local_max_x,
    input  logic signed [COORD_WIDTH-1:0] i_local_max_y,
    input  logic signed [COORD_WIDTH-1:0] i_local_max_z,

    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_world_min_x,
    output logic signed [COORD_WIDTH-1:0] o_world_min_y,
    output logic signed [COORD_WIDTH-1:0] o_world_min_z,
    output logic signed [COORD_WIDTH-1:0] o_world_max_x,
    output logic signed [COORD_WIDTH-1:0] o_world_max_y,
    output logic signed [COORD_WIDTH-1:0] o_world_max_z,
    output logic                          o_box_valid
);

    logic [ROW_W-1:0]    r_row [AXES];
    logic [OFFSET_W-1:0] r_off [AXES];

    logic [3:0] r_vld;
    logic       r_ok1;
    logic       r_ok2;
    logic       r_ok3;
    logic       r_ok4;

    t_stage_en en;
    logic      wr_req;
    logic [REG_IDX_W-1:0] reg_idx;
    logic      box_ok;

    logic signed [COORD_WIDTH-1:0] lmin [AXES];
    logic signed [COORD_WIDTH-1:0] lmax [AXES];
    logic        [COORD_WIDTH-1:0] wmin [AXES];
    logic        [COORD_WIDTH-1:0] wmax [AXES];

    // configuration port
    assign pready  = 1'b1;
    assign wr_req  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= X_ROW_RESET;
            r_row[1] <= Y_ROW_RESET;
            r_row[2] <= Z_ROW_RESET;
            r_off[0] <= '0;
            r_off[1] <= '0;
            r_off[2] <= '0;
        end else if (wr_req) begin
            unique case (reg_idx)
                REG_X_ROW:    r_row[0] <= pwdata[ROW_W-1:0];
                REG_Y_ROW:    r_row[1] <= pwdata[ROW_W-1:0];
                REG_Z_ROW:    r_row[2] <= pwdata[ROW_W-1:0];
                REG_OFFSET_X: r_off[0] <= pwdata[OFFSET_W-1:0];
                REG_OFFSET_Y: r_off[1] <= pwdata[OFFSET_W-1:0];
                REG_OFFSET_Z: r_off[2] <= pwdata[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_X_ROW:    prdata = {{(APB_DATA_W-ROW_W){1'b0}}, r_row[0]};
            REG_Y_ROW:    prdata = {{(APB_DATA_W-ROW_W){1'b0}}, r_row[1]};
            REG_Z_ROW:    prdata = {{(APB_DATA_W-ROW_W){1'b0}}, r_row[2]};
            REG_OFFSET_X: prdata = {{(APB_DATA_W-OFFSET_W){1'b0}}, r_off[0]};
            REG_OFFSET_Y: prdata = {{(APB_DATA_W-OFFSET_W){1'b0}}, r_off[1]};
            REG_OFFSET_Z: prdata = {{(APB_DATA_W-OFFSET_W){1'b0}}, r_off[2]};
            default:      prdata = '0;
        endcase
    end

    // pipeline flow control
    always_comb begin
        en.s4 = !r_vld[3] || i_ready;
        en.s3 = !r_vld[2] || en.s4;
        en.s2 = !r_vld[1] || en.s3;
        en.s1 = !r_vld[0] || en.s2;
    end

    assign o_ready = en.s1;
    assign o_valid = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en.s1) r_vld[0] <= i_valid;
            if (en.s2) r_vld[1] <= r_vld[0];
            if (en.s3) r_vld[2] <= r_vld[1];
            if (en.s4) r_vld[3] <= r_vld[2];
        end
    end

    assign box_ok = (i_local_min_x <= i_local_max_x)
                 && (i_local_min_y <= i_local_max_y)
                 && (i_local_min_z <= i_local_max_z);

    always_ff @(posedge i_clk) begin
        if (en.s1) r_ok1 <= box_ok;
        if (en.s2) r_ok2 <= r_ok1;
        if (en.s3) r_ok3 <= r_ok2;
        if (en.s4) r_ok4 <= r_ok3;
    end

    assign lmin[0] = i_local_min_x;
    assign lmin[1] = i_local_min_y;
    assign lmin[2] = i_local_min_z;
    assign lmax[0] = i_local_max_x;
    assign lmax[1] = i_local_max_y;
    assign lmax[2] = i_local_max_z;

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        logic signed [WEIGHT_W-1:0] w [AXES];

        for (genvar i = 0; i < AXES; i++) begin : g_w
            assign w[i] = $signed(r_row[i][a*WEIGHT_W +: WEIGHT_W]);
        end

        aat_lane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_lmin   (lmin),
            .i_lmax   (lmax),
            .i_w      (w),
            .i_offset ($signed(r_off[a])),
            .i_box_ok (r_ok3),
            .o_min    (wmin[a]),
            .o_max    (wmax[a])
        );
    end

    assign o_world_min_x = $signed(wmin[0]);
    assign o_world_min_y = $signed(wmin[1]);
    assign o_world_min_z = $signed(wmin[2]);
    assign o_world_max_x = $signed(wmax[0]);
    assign o_world_max_y = $signed(wmax[1]);
    assign o_world_max_z = $signed(wmax[2]);
    assign o_box_valid   = r_ok4;

`ifndef ASSERT_OFF
    // rejected box leaves as all zeros
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_box_valid) |->
            (o_world_min_x == '0) && (o_world_min_y == '0) && (o_world_min_z == '0) &&
            (o_world_max_x == '0) && (o_world_max_y == '0) && (o_world_max_z == '0))
        else $error("rejected box with nonzero coordinates");

    // accepted box keeps min at or below max
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_box_valid) |->
            (o_world_min_x <= o_world_max_x) && (o_world_min_y <= o_world_max_y) &&
            (o_world_min_z <= o_world_max_z))
        else $error("world min above world max");

    // an empty first stage always takes a request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[0] |-> o_ready)
        else $error("pipeline refuses request with free entry stage");

    // a full stalled pipeline takes nothing
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_ready) |-> !o_ready)
        else $error("full stalled pipeline accepts request");
`endif

endmodule

>>> design/aat_lane.sv
// ----------------------------------------------------------------------------
// aat_lane
// one world axis: weighted min/max terms, exact sum, floor, offset, saturate
// ----------------------------------------------------------------------------
module aat_lane
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  t_stage_en                     i_en,
    input  logic signed [COORD_WIDTH-1:0] i_lmin [AXES],
    input  logic signed [COORD_WIDTH-1:0] i_lmax [AXES],
    input  logic signed [WEIGHT_W-1:0]    i_w [AXES],
    input  logic signed [OFFSET_W-1:0]    i_offset,
    input  logic                          i_box_ok,
    output logic        [COORD_WIDTH-1:0] o_min,
    output logic        [COORD_WIDTH-1:0] o_max
);

    localparam int PROD_W = COORD_WIDTH + WEIGHT_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SHR_W  = SUM_W - WEIGHT_FRAC;
    localparam int ACC_W  = ((SHR_W > OFFSET_W) ? SHR_W : OFFSET_W) + 1;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        $signed({{(ACC_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_LO =
        $signed({{(ACC_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}});

    logic signed [PROD_W-1:0] r_p  [AXES];
    logic signed [PROD_W-1:0] r_q  [AXES];
    logic signed [PROD_W-1:0] r_lo [AXES];
    logic signed [PROD_W-1:0] r_hi [AXES];
    logic        [SUM_W-1:0]  r_sum_lo;
    logic        [SUM_W-1:0]  r_sum_hi;
    logic        [COORD_WIDTH-1:0] r_min;
    logic        [COORD_WIDTH-1:0] r_max;

    logic [SUM_W-1:0] n_sum_lo;
    logic [SUM_W-1:0] n_sum_hi;
    logic signed [ACC_W-1:0] acc_lo;
    logic signed [ACC_W-1:0] acc_hi;

    function automatic logic [SUM_W-1:0] sext_prod(input logic [PROD_W-1:0] v);
        return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
    endfunction

    function automatic logic signed [ACC_W-1:0] to_acc(input logic [SUM_W-1:0] s,
                                                      input logic [OFFSET_W-1:0] off);
        logic [SHR_W-1:0] shr;
        shr = s[SUM_W-1:WEIGHT_FRAC];
        return $signed({{(ACC_W-SHR_W){shr[SHR_W-1]}}, shr})
             + $signed({{(ACC_W-OFFSET_W){off[OFFSET_W-1]}}, off});
    endfunction

    function automatic logic [COORD_WIDTH-1:0] sat(input logic signed [ACC_W-1:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[COORD_WIDTH-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[COORD_WIDTH-1:0];
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int i = 0; i < AXES; i++) begin
                r_p[i] <= PROD_W'(i_w[i]) * PROD_W'(i_lmin[i]);
                r_q[i] <= PROD_W'(i_w[i]) * PROD_W'(i_lmax[i]);
            end
        end
    end

    // stage 2: per-term extremes
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int i = 0; i < AXES; i++) begin
                r_lo[i] <= (r_p[i] < r_q[i]) ? r_p[i] : r_q[i];
                r_hi[i] <= (r_p[i] < r_q[i]) ? r_q[i] : r_p[i];
            end
        end
    end

    // stage 3: exact sums
    always_comb begin
        n_sum_lo = sext_prod(r_lo[0]) + sext_prod(r_lo[1]) + sext_prod(r_lo[2]);
        n_sum_hi = sext_prod(r_hi[0]) + sext_prod(r_hi[1]) + sext_prod(r_hi[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_sum_lo <= n_sum_lo;
            r_sum_hi <= n_sum_hi;
        end
    end

    // stage 4: floor, offset, saturate
    always_comb begin
        acc_lo = to_acc(r_sum_lo, i_offset);
        acc_hi = to_acc(r_sum_hi, i_offset);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_min <= i_box_ok ? sat(acc_lo) : '0;
            r_max <= i_box_ok ? sat(acc_hi) : '0;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule
